>>> rtl/core/alu16_flags_branch_test_assert.svh
// Assertion macros for the 16-bit flag ALU.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef ALU16_FLAGS_BRANCH_TEST_ASSERT_SVH
`define ALU16_FLAGS_BRANCH_TEST_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define A16FB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("a16fb: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define A16FB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("a16fb: next-cycle check failed");

`endif

>>> rtl/core/a16fb_pkg.sv
// Shared codes and widths for the 16-bit flag ALU.
// No dependencies.
package a16fb_pkg;

    localparam int unsigned DataW = 16;

    typedef enum logic [3:0] {
        FUNC_ADD = 4'd0,
        FUNC_SUB = 4'd1,
        FUNC_AND = 4'd2,
        FUNC_OR  = 4'd3,
        FUNC_XOR = 4'd4,
        FUNC_NOR = 4'd5,
        FUNC_SHL = 4'd6,
        FUNC_SRA = 4'd7,
        FUNC_SRL = 4'd8,
        FUNC_LUI = 4'd9,
        FUNC_LLI = 4'd10
    } t_func;

    typedef enum logic [1:0] {
        EXT_NONE = 2'd0,
        EXT_SIGN = 2'd1,
        EXT_ZERO = 2'd2,
        EXT_REPL = 2'd3
    } t_ext;

    typedef enum logic [2:0] {
        COND_EQ  = 3'd0,
        COND_NE  = 3'd1,
        COND_GT  = 3'd2,
        COND_NGT = 3'd3,
        COND_LT  = 3'd4,
        COND_NLT = 3'd5
    } t_cond;

    typedef struct packed {
        logic [DataW-1:0] operand_a;
        logic [DataW-1:0] operand_b;
        logic [3:0]       func;
        logic [1:0]       extend_mode;
        logic             use_carry_in;
        logic [2:0]       cond;
    } t_item;

    typedef struct packed {
        logic [DataW-1:0] result;
        logic             carry_flag;
        logic             negative_flag;
        logic             zero_flag;
        logic             branch_taken;
    } t_res;

endpackage

>>> rtl/core/a16fb_in_if.sv
// Operation channel of the 16-bit flag ALU: valid, ready and operand fields.
// Depends on a16fb_pkg.
interface a16fb_in_if
    import a16fb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic [3:0]       func;
    logic [1:0]       extend_mode;
    logic             use_carry_in;
    logic [2:0]       cond;

    modport source (
        output valid, operand_a, operand_b, func, extend_mode, use_carry_in, cond,
        input  ready
    );

    modport sink (
        input  valid, operand_a, operand_b, func, extend_mode, use_carry_in, cond,
        output ready
    );
endinterface

>>> rtl/core/a16fb_out_if.sv
// Result channel of the 16-bit flag ALU: valid, ready, result and flags.
// Depends on a16fb_pkg.
interface a16fb_out_if
    import a16fb_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [DataW-1:0] result;
    logic             carry_flag;
    logic             negative_flag;
    logic             zero_flag;
    logic             branch_taken;

    modport source (
        output valid, result, carry_flag, negative_flag, zero_flag, branch_taken,
        input  ready
    );

    modport sink (
        input  valid, result, carry_flag, negative_flag, zero_flag, branch_taken,
        output ready
    );
endinterface

>>> rtl/core/alu16_flags_branch_test.sv
// 16-bit ALU with carry, negative and zero flags and a branch decision.
// An accepted transaction is registered in the input stage, then moves to the output stage.
// Throughput: one transaction per cycle while the result channel is not stalled.
// Reset: synchronous, active low; clears both valid stages and the stored carry.
// Depends on a16fb_pkg, a16fb_in_if, a16fb_out_if and the assertion header.
`include "alu16_flags_branch_test_assert.svh"

module alu16_flags_branch_test
    import a16fb_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    a16fb_in_if.sink      i_in,
    a16fb_out_if.source   o_out
);

    logic             r_in_vld;
    t_item            r_in;
    logic             r_out_vld;
    t_res             r_out;
    logic             r_carry;

    logic             w_move;
    logic [DataW-1:0] w_b;
    logic [DataW-1:0] w_bneg;
    logic [DataW:0]   w_sum;
    logic [4:0]       w_sh;
    logic [2*DataW-1:0] w_shl;
    logic [2*DataW-1:0] w_sra;
    logic             w_cin;
    t_res             n_out;

    assign w_move    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_carry   <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
                r_carry   <= n_out.carry_flag;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.operand_a    <= i_in.operand_a;
            r_in.operand_b    <= i_in.operand_b;
            r_in.func         <= i_in.func;
            r_in.extend_mode  <= i_in.extend_mode;
            r_in.use_carry_in <= i_in.use_carry_in;
            r_in.cond         <= i_in.cond;
        end
        if (w_move) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        unique case (t_ext'(r_in.extend_mode))
            EXT_SIGN: w_b = {{8{r_in.operand_b[7]}}, r_in.operand_b[7:0]};
            EXT_ZERO: w_b = {8'h00, r_in.operand_b[7:0]};
            EXT_REPL: w_b = {DataW{r_in.operand_b[7]}};
            default:  w_b = r_in.operand_b;
        endcase
    end

    assign w_cin  = r_in.use_carry_in & r_carry;
    assign w_bneg = (r_in.func == FUNC_SUB) ? (~w_b + DataW'(1)) : w_b;
    assign w_sum  = {1'b0, r_in.operand_a} + {1'b0, w_bneg} + {{DataW{1'b0}}, w_cin};
    assign w_sh   = {1'b0, w_b[3:0]} + 5'd1;
    assign w_shl  = {{DataW{1'b0}}, r_in.operand_a} << w_sh;
    assign w_sra  = $unsigned($signed({{DataW{r_in.operand_a[DataW-1]}}, r_in.operand_a})
                    >>> w_sh);

    always_comb begin
        n_out = '0;
        unique case (t_func'(r_in.func))
            FUNC_ADD, FUNC_SUB: begin
                n_out.result     = w_sum[DataW-1:0];
                n_out.carry_flag = w_sum[DataW];
            end
            FUNC_AND: n_out.result = r_in.operand_a & w_b;
            FUNC_OR:  n_out.result = r_in.operand_a | w_b;
            FUNC_XOR: n_out.result = r_in.operand_a ^ w_b;
            FUNC_NOR: begin
                n_out.result     = ~(r_in.operand_a | w_b);
                n_out.carry_flag = 1'b1;
            end
            FUNC_SHL: begin
                n_out.result     = w_shl[DataW-1:0];
                n_out.carry_flag = |w_shl[2*DataW-1:DataW];
            end
            FUNC_SRA: n_out.result = w_sra[DataW-1:0];
            FUNC_SRL: n_out.result = r_in.operand_a >> w_sh;
            FUNC_LUI: n_out.result = {w_b[7:0], 8'h00};
            FUNC_LLI: n_out.result = {8'h00, w_b[7:0]};
            default:  n_out.result = '0;
        endcase
        n_out.negative_flag = n_out.result[DataW-1];
        n_out.zero_flag     = (n_out.result == '0);
        unique case (t_cond'(r_in.cond))
            COND_EQ:  n_out.branch_taken = n_out.zero_flag;
            COND_NE:  n_out.branch_taken = !n_out.zero_flag;
            COND_GT:  n_out.branch_taken = !(n_out.zero_flag || n_out.negative_flag);
            COND_NGT: n_out.branch_taken = n_out.zero_flag || n_out.negative_flag;
            COND_LT:  n_out.branch_taken = n_out.negative_flag;
            COND_NLT: n_out.branch_taken = !n_out.negative_flag;
            default:  n_out.branch_taken = 1'b0;
        endcase
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.result        = r_out.result;
    assign o_out.carry_flag    = r_out.carry_flag;
    assign o_out.negative_flag = r_out.negative_flag;
    assign o_out.zero_flag     = r_out.zero_flag;
    assign o_out.branch_taken  = r_out.branch_taken;

    `A16FB_ASSERT_NEXT(a_carry_tracks_flag, w_move, r_carry == r_out.carry_flag && r_out_vld)
    `A16FB_ASSERT_SAME(a_in_stall_cause, r_in_vld && !i_in.ready, r_out_vld && !o_out.ready)
    `A16FB_ASSERT_SAME(a_flag_sign, o_out.valid, o_out.negative_flag == o_out.result[DataW-1])

endmodule

>>> test/alu16_flags_checker.sv
`timescale 1ns / 1ps
// Result checker for the 16-bit flag ALU: watches both channels, predicts each result.
// Depends on a16fb_pkg, a16fb_in_if and a16fb_out_if.
module alu16_flags_checker
    import a16fb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    a16fb_in_if  i_op_mon,
    a16fb_out_if i_res_mon,
    output int   o_fail_count,
    output int   o_pending
);

    t_res        expected_flags[$];
    logic        carry_track;
    int          failure_total;
    t_item       seen_op;
    t_res        seen_res;
    t_res        want_res;

    initial begin
        carry_track   = 1'b0;
        failure_total = 0;
        o_fail_count  = 0;
        o_pending     = 0;
    end

    function automatic t_res alu_outcome(input t_item op, input logic carry_in);
        logic [15:0] b_ext;
        logic [15:0] b_neg;
        logic [31:0] raw;
        logic [31:0] a_sext;
        logic [4:0]  amount;
        logic        cin;
        t_res        r;
        case (op.extend_mode)
            EXT_SIGN: b_ext = {{8{op.operand_b[7]}}, op.operand_b[7:0]};
            EXT_ZERO: b_ext = {8'h00, op.operand_b[7:0]};
            EXT_REPL: b_ext = {16{op.operand_b[7]}};
            default:  b_ext = op.operand_b;
        endcase
        b_neg  = ~b_ext + 16'd1;
        a_sext = {{16{op.operand_a[15]}}, op.operand_a};
        amount = {1'b0, b_ext[3:0]} + 5'd1;
        cin    = op.use_carry_in & carry_in;
        case (op.func)
            FUNC_ADD: raw = {16'h0, op.operand_a} + {16'h0, b_ext} + {31'h0, cin};
            FUNC_SUB: raw = {16'h0, op.operand_a} + {16'h0, b_neg} + {31'h0, cin};
            FUNC_AND: raw = {16'h0, op.operand_a & b_ext};
            FUNC_OR:  raw = {16'h0, op.operand_a | b_ext};
            FUNC_XOR: raw = {16'h0, op.operand_a ^ b_ext};
            FUNC_NOR: raw = ~{16'h0, op.operand_a | b_ext};
            FUNC_SHL: raw = {16'h0, op.operand_a} << amount;
            FUNC_SRA: raw = (a_sext >> amount) & 32'h0000_ffff;
            FUNC_SRL: raw = {16'h0, op.operand_a} >> amount;
            FUNC_LUI: raw = {16'h0, b_ext[7:0], 8'h00};
            FUNC_LLI: raw = {24'h0, b_ext[7:0]};
            default:  raw = '0;
        endcase
        r.result        = raw[15:0];
        r.carry_flag    = |raw[31:16];
        r.negative_flag = raw[15];
        r.zero_flag     = (raw[15:0] == 16'h0);
        case (op.cond)
            COND_EQ:  r.branch_taken = r.zero_flag;
            COND_NE:  r.branch_taken = !r.zero_flag;
            COND_GT:  r.branch_taken = !(r.zero_flag | r.negative_flag);
            COND_NGT: r.branch_taken = r.zero_flag | r.negative_flag;
            COND_LT:  r.branch_taken = r.negative_flag;
            COND_NLT: r.branch_taken = !r.negative_flag;
            default:  r.branch_taken = 1'b0;
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        if (failure_total < 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
        failure_total++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            carry_track = 1'b0;
            expected_flags.delete();
        end else begin
            if (i_res_mon.valid && i_res_mon.ready) begin
                seen_res.result        = i_res_mon.result;
                seen_res.carry_flag    = i_res_mon.carry_flag;
                seen_res.negative_flag = i_res_mon.negative_flag;
                seen_res.zero_flag     = i_res_mon.zero_flag;
                seen_res.branch_taken  = i_res_mon.branch_taken;
                if (expected_flags.size() == 0) begin
                    note_failure($sformatf("unexpected result res=%h c=%b n=%b z=%b br=%b",
                        seen_res.result, seen_res.carry_flag, seen_res.negative_flag,
                        seen_res.zero_flag, seen_res.branch_taken));
                end else begin
                    want_res = expected_flags.pop_front();
                    if (seen_res.result !== want_res.result
                            || seen_res.carry_flag !== want_res.carry_flag
                            || seen_res.negative_flag !== want_res.negative_flag
                            || seen_res.zero_flag !== want_res.zero_flag
                            || seen_res.branch_taken !== want_res.branch_taken) begin
                        note_failure($sformatf(
                            "mismatch: exp res=%h c=%b n=%b z=%b br=%b, got res=%h c=%b n=%b z=%b br=%b",
                            want_res.result, want_res.carry_flag, want_res.negative_flag,
                            want_res.zero_flag, want_res.branch_taken,
                            seen_res.result, seen_res.carry_flag, seen_res.negative_flag,
                            seen_res.zero_flag, seen_res.branch_taken));
                    end
                end
            end
            if (i_op_mon.valid && i_op_mon.ready) begin
                seen_op.operand_a    = i_op_mon.operand_a;
                seen_op.operand_b    = i_op_mon.operand_b;
                seen_op.func         = i_op_mon.func;
                seen_op.extend_mode  = i_op_mon.extend_mode;
                seen_op.use_carry_in = i_op_mon.use_carry_in;
                seen_op.cond         = i_op_mon.cond;
                want_res = alu_outcome(seen_op, carry_track);
                carry_track = want_res.carry_flag;
                expected_flags.push_back(want_res);
            end
        end
        o_pending    <= expected_flags.size();
        o_fail_count <= failure_total;
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Top of the 16-bit flag ALU test: clock, reset, operation stimulus and verdict.
// Depends on a16fb_pkg, the ALU channel interfaces, the ALU and alu16_flags_checker.
module testbench;
    import a16fb_pkg::*;

    localparam logic [3:0] FUNC_NONE_LO  = 4'd11;
    localparam logic [3:0] FUNC_NONE_HI  = 4'd15;
    localparam logic [2:0] COND_NEVER_LO = 3'd6;
    localparam logic [2:0] COND_NEVER_HI = 3'd7;
    localparam int         PHASE_ITEMS   = 425;
    localparam int         QUIET_LIMIT   = 1000;

    logic        clk;
    logic        rst_n;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int          fail_count;
    int          pending;
    int unsigned idle_plan[4];
    int unsigned stall_plan[4];

    a16fb_in_if  in_ch();
    a16fb_out_if out_ch();

    alu16_flags_branch_test dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    alu16_flags_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_op_mon     (in_ch),
        .i_res_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_item make_op(input logic [15:0] a, input logic [15:0] b,
                                      input logic [3:0] f, input logic [1:0] e,
                                      input logic c, input logic [2:0] k);
        t_item it;
        it.operand_a    = a;
        it.operand_b    = b;
        it.func         = f;
        it.extend_mode  = e;
        it.use_carry_in = c;
        it.cond         = k;
        return it;
    endfunction

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'h8000;
            3:       return 16'h7fff;
            default: return 16'($urandom_range(16'hffff));
        endcase
    endfunction

    // Bias toward add/sub with carry-in so carry chains run long.
    function automatic t_item random_op();
        t_item it;
        it.operand_a = pick_operand();
        it.operand_b = pick_operand();
        if ($urandom_range(99) < 40) begin
            it.func = $urandom_range(1) ? FUNC_SUB : FUNC_ADD;
        end else begin
            it.func = 4'($urandom_range(15));
        end
        it.extend_mode  = 2'($urandom_range(3));
        it.use_carry_in = ($urandom_range(3) != 0);
        it.cond         = 3'($urandom_range(7));
        return it;
    endfunction

    task automatic send_op(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.operand_a    <= it.operand_a;
        in_ch.operand_b    <= it.operand_b;
        in_ch.func         <= it.func;
        in_ch.extend_mode  <= it.extend_mode;
        in_ch.use_carry_in <= it.use_carry_in;
        in_ch.cond         <= it.cond;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Hold off new transactions until every predicted result is back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        rst_n              = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        in_ch.valid        = 1'b0;
        in_ch.operand_a    = '0;
        in_ch.operand_b    = '0;
        in_ch.func         = '0;
        in_ch.extend_mode  = '0;
        in_ch.use_carry_in = 1'b0;
        in_ch.cond         = '0;
        out_ch.ready       = 1'b0;
        idle_plan          = '{0, 71, 0, 8};
        stall_plan         = '{0, 0, 71, 8};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_op(make_op(16'hffff, 16'hffff, FUNC_ADD, EXT_NONE, 1'b0, COND_EQ));
        send_op(make_op(16'h0000, 16'h0000, FUNC_ADD, EXT_NONE, 1'b1, COND_EQ));
        send_op(make_op(16'h0000, 16'h0000, FUNC_ADD, EXT_NONE, 1'b0, COND_EQ));
        send_op(make_op(16'h0005, 16'h0000, FUNC_SUB, EXT_NONE, 1'b0, COND_NE));
        send_op(make_op(16'h0000, 16'h0001, FUNC_SUB, EXT_NONE, 1'b0, COND_LT));
        send_op(make_op(16'h7fff, 16'hffff, FUNC_SUB, EXT_NONE, 1'b1, COND_GT));
        send_op(make_op(16'hffff, 16'hffff, FUNC_AND, EXT_NONE, 1'b1, COND_GT));
        send_op(make_op(16'h0000, 16'h0000, FUNC_OR, EXT_NONE, 1'b0, COND_NGT));
        send_op(make_op(16'hffff, 16'h00ff, FUNC_XOR, EXT_ZERO, 1'b0, COND_NLT));
        send_op(make_op(16'h0000, 16'h0000, FUNC_NOR, EXT_NONE, 1'b0, COND_LT));
        send_op(make_op(16'hffff, 16'hffff, FUNC_NOR, EXT_NONE, 1'b1, COND_EQ));
        send_op(make_op(16'hffff, 16'h000f, FUNC_SHL, EXT_NONE, 1'b0, COND_EQ));
        send_op(make_op(16'h8000, 16'h0000, FUNC_SHL, EXT_NONE, 1'b0, COND_NE));
        send_op(make_op(16'h8000, 16'h000f, FUNC_SRA, EXT_NONE, 1'b0, COND_LT));
        send_op(make_op(16'h7fff, 16'h000f, FUNC_SRA, EXT_NONE, 1'b0, COND_NGT));
        send_op(make_op(16'hffff, 16'h000f, FUNC_SRL, EXT_NONE, 1'b0, COND_EQ));
        send_op(make_op(16'hffff, 16'h0000, FUNC_SRL, EXT_ZERO, 1'b0, COND_GT));
        send_op(make_op(16'h1234, 16'h0080, FUNC_LUI, EXT_SIGN, 1'b0, COND_LT));
        send_op(make_op(16'h0000, 16'hffff, FUNC_LLI, EXT_REPL, 1'b0, COND_NLT));
        send_op(make_op(16'hffff, 16'hffff, FUNC_NONE_LO, EXT_REPL, 1'b1, COND_NEVER_LO));
        send_op(make_op(16'hffff, 16'hffff, FUNC_NONE_HI, EXT_SIGN, 1'b1, COND_NEVER_HI));
        send_op(make_op(16'h0080, 16'h0080, FUNC_ADD, EXT_SIGN, 1'b0, COND_NE));
        send_op(make_op(16'h0001, 16'h007f, FUNC_ADD, EXT_REPL, 1'b1, COND_EQ));
        send_op(make_op(16'hff00, 16'hff80, FUNC_SUB, EXT_SIGN, 1'b1, COND_NLT));
        drain_results();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_plan[p];
            recv_stall_pct <= stall_plan[p];
            repeat (PHASE_ITEMS) send_op(random_op());
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
